### src/bse_pkg.sv
// ----------------------------------------------------------------------------
// Battery SOC EKF step: shared package
// Types, constants, micro-program and saturating arithmetic helpers.
// ----------------------------------------------------------------------------
package bse_pkg;

  localparam int unsigned WORD_WIDTH_DEF = 64;
  localparam int unsigned PROG_LEN       = 59;
  localparam int unsigned PC_W           = $clog2(PROG_LEN);

  localparam logic [63:0] ONE_Q = 64'd1 << 48;

  localparam logic signed [63:0] OCV_C0 = ((64'd16026 << 44) + 64'd312) / 64'd625;
  localparam logic signed [63:0] OCV_C1 = -(((64'd82896 << 44) + 64'd312) / 64'd625);
  localparam logic signed [63:0] OCV_C2 = ((64'd148878 << 44) + 64'd312) / 64'd625;
  localparam logic signed [63:0] OCV_C3 = -(((64'd120873 << 44) + 64'd312) / 64'd625);
  localparam logic signed [63:0] OCV_C4 = ((64'd55781 << 44) + 64'd312) / 64'd625;
  localparam logic signed [63:0] OCV_C5 = ((64'd25047 << 44) + 64'd312) / 64'd625;
  localparam logic signed [63:0] DOCV_C0 = ((64'd80130 << 44) + 64'd312) / 64'd625;
  localparam logic signed [63:0] DOCV_C1 = -(((64'd331584 << 44) + 64'd312) / 64'd625);
  localparam logic signed [63:0] DOCV_C2 = ((64'd446634 << 44) + 64'd312) / 64'd625;
  localparam logic signed [63:0] DOCV_C3 = -(((64'd241746 << 44) + 64'd312) / 64'd625);
  localparam logic signed [63:0] DOCV_C4 = ((64'd55781 << 44) + 64'd312) / 64'd625;

  localparam logic signed [63:0] CHG_RESET  = ((64'd9 << 48) + 64'd5) / 64'd10;
  localparam logic signed [63:0] COV0_RESET = ((64'd1 << 48) + 64'd50000000) / 64'd100000000;
  localparam logic signed [63:0] COV3_RESET = ((64'd1 << 48) + 64'd500000) / 64'd1000000;

  typedef enum logic [2:0] {
    CFG_DECAY  = 3'd0,
    CFG_PGAIN  = 3'd1,
    CFG_CGAIN  = 3'd2,
    CFG_OHMIC  = 3'd3,
    CFG_PNOISE = 3'd4,
    CFG_MNOISE = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_ADDCL, OP_MUL, OP_DIV, OP_END
  } op_e;

  typedef enum logic [5:0] {
    R_A, R_PG, R_CG, R_R0, R_Q, R_R, R_V, R_CUR,
    R_POLQ, R_CHGQ, R_P0, R_P1, R_P2, R_P3,
    R_X1, R_X2, R_POL, R_CHG, R_PP0, R_PP1, R_PP2, R_PP3,
    R_C, R_G0, R_G1, R_S, R_K0, R_K1, R_RES, R_H,
    R_D0, R_D1, R_D2, R_D3, R_D4,
    R_O0, R_O1, R_O2, R_O3, R_O4, R_O5
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE, ST_ISSUE, ST_WAIT
  } state_e;

  typedef struct packed {
    op_e  op;
    reg_e dst;
    reg_e src_a;
    reg_e src_b;
  } uop_t;

  typedef struct packed {
    logic            busy;
    logic [PC_W-1:0] pc;
    logic            wr_en;
    logic            mul_start;
    logic            div_start;
    logic            out_load;
  } ctrl_t;

  function automatic logic [63:0] mag(logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic signed [63:0] from_mag(logic neg, logic [63:0] m, int unsigned w);
    logic [63:0] lim;
    lim = 64'd1 << (w - 1);
    if (neg) begin
      return (m >= lim) ? signed'(64'(-lim)) : signed'(64'(-m));
    end
    return (m >= lim) ? signed'(64'(lim - 64'd1)) : signed'(m);
  endfunction

  function automatic logic signed [63:0] sat_w(logic signed [64:0] x, int unsigned w);
    logic signed [64:0] hi;
    logic signed [64:0] lo;
    hi = signed'((65'd1 << (w - 1)) - 65'd1);
    lo = -hi - 65'sd1;
    if (x > hi) return hi[63:0];
    if (x < lo) return lo[63:0];
    return x[63:0];
  endfunction

  function automatic logic signed [63:0] clamp01(logic signed [63:0] x);
    if (x < 0) return '0;
    if (x > signed'(ONE_Q)) return signed'(ONE_Q);
    return x;
  endfunction

  function automatic uop_t prog(logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = '{OP_MUL,   R_X1,   R_A,    R_POLQ};
      6'd1:  u = '{OP_MUL,   R_X2,   R_PG,   R_CUR};
      6'd2:  u = '{OP_ADD,   R_POL,  R_X1,   R_X2};
      6'd3:  u = '{OP_MUL,   R_X1,   R_CG,   R_CUR};
      6'd4:  u = '{OP_ADDCL, R_CHG,  R_CHGQ, R_X1};
      6'd5:  u = '{OP_MUL,   R_X1,   R_A,    R_P0};
      6'd6:  u = '{OP_MUL,   R_X1,   R_A,    R_X1};
      6'd7:  u = '{OP_ADD,   R_PP0,  R_X1,   R_Q};
      6'd8:  u = '{OP_MUL,   R_PP1,  R_A,    R_P1};
      6'd9:  u = '{OP_MUL,   R_PP2,  R_A,    R_P2};
      6'd10: u = '{OP_ADD,   R_PP3,  R_P3,   R_Q};
      6'd11: u = '{OP_MUL,   R_X1,   R_D0,   R_CHG};
      6'd12: u = '{OP_ADD,   R_C,    R_X1,   R_D1};
      6'd13: u = '{OP_MUL,   R_X1,   R_C,    R_CHG};
      6'd14: u = '{OP_ADD,   R_C,    R_X1,   R_D2};
      6'd15: u = '{OP_MUL,   R_X1,   R_C,    R_CHG};
      6'd16: u = '{OP_ADD,   R_C,    R_X1,   R_D3};
      6'd17: u = '{OP_MUL,   R_X1,   R_C,    R_CHG};
      6'd18: u = '{OP_ADD,   R_C,    R_X1,   R_D4};
      6'd19: u = '{OP_MUL,   R_X1,   R_PP1,  R_C};
      6'd20: u = '{OP_ADD,   R_G0,   R_PP0,  R_X1};
      6'd21: u = '{OP_MUL,   R_X1,   R_PP3,  R_C};
      6'd22: u = '{OP_ADD,   R_G1,   R_PP2,  R_X1};
      6'd23: u = '{OP_MUL,   R_X1,   R_C,    R_G1};
      6'd24: u = '{OP_ADD,   R_S,    R_G0,   R_X1};
      6'd25: u = '{OP_ADD,   R_S,    R_S,    R_R};
      6'd26: u = '{OP_DIV,   R_K0,   R_G0,   R_S};
      6'd27: u = '{OP_DIV,   R_K1,   R_G1,   R_S};
      6'd28: u = '{OP_MUL,   R_X1,   R_R0,   R_CUR};
      6'd29: u = '{OP_SUB,   R_RES,  R_V,    R_X1};
      6'd30: u = '{OP_MUL,   R_X1,   R_O0,   R_CHG};
      6'd31: u = '{OP_ADD,   R_H,    R_X1,   R_O1};
      6'd32: u = '{OP_MUL,   R_X1,   R_H,    R_CHG};
      6'd33: u = '{OP_ADD,   R_H,    R_X1,   R_O2};
      6'd34: u = '{OP_MUL,   R_X1,   R_H,    R_CHG};
      6'd35: u = '{OP_ADD,   R_H,    R_X1,   R_O3};
      6'd36: u = '{OP_MUL,   R_X1,   R_H,    R_CHG};
      6'd37: u = '{OP_ADD,   R_H,    R_X1,   R_O4};
      6'd38: u = '{OP_MUL,   R_X1,   R_H,    R_CHG};
      6'd39: u = '{OP_ADD,   R_H,    R_X1,   R_O5};
      6'd40: u = '{OP_SUB,   R_RES,  R_RES,  R_H};
      6'd41: u = '{OP_SUB,   R_RES,  R_RES,  R_POL};
      6'd42: u = '{OP_MUL,   R_X1,   R_K0,   R_RES};
      6'd43: u = '{OP_ADD,   R_POLQ, R_POL,  R_X1};
      6'd44: u = '{OP_MUL,   R_X1,   R_K1,   R_RES};
      6'd45: u = '{OP_ADDCL, R_CHGQ, R_CHG,  R_X1};
      6'd46: u = '{OP_MUL,   R_X1,   R_C,    R_PP2};
      6'd47: u = '{OP_ADD,   R_H,    R_PP0,  R_X1};
      6'd48: u = '{OP_MUL,   R_X1,   R_C,    R_PP3};
      6'd49: u = '{OP_ADD,   R_G1,   R_PP1,  R_X1};
      6'd50: u = '{OP_MUL,   R_X1,   R_K0,   R_H};
      6'd51: u = '{OP_SUB,   R_P0,   R_PP0,  R_X1};
      6'd52: u = '{OP_MUL,   R_X1,   R_K0,   R_G1};
      6'd53: u = '{OP_SUB,   R_P1,   R_PP1,  R_X1};
      6'd54: u = '{OP_MUL,   R_X1,   R_K1,   R_H};
      6'd55: u = '{OP_SUB,   R_P2,   R_PP2,  R_X1};
      6'd56: u = '{OP_MUL,   R_X1,   R_K1,   R_G1};
      6'd57: u = '{OP_SUB,   R_P3,   R_PP3,  R_X1};
      default: u = '{OP_END, R_X1,   R_X1,   R_X1};
    endcase
    return u;
  endfunction

endpackage

### src/bse_mul.sv
// ----------------------------------------------------------------------------
// Battery SOC EKF step: shared multiplier
// Q15.48 product from four 32x32 partial products, rounded and saturated.
// ----------------------------------------------------------------------------
module bse_mul import bse_pkg::*; #(
  parameter int unsigned WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  output logic               done_o,
  output logic signed [63:0] res_o
);

  logic         busy_q;
  logic [2:0]   cnt_q;
  logic [63:0]  ua_q, ub_q;
  logic         neg_q;
  logic [127:0] acc_q;
  logic         done_q;
  logic signed [63:0] res_q;

  logic [31:0]  ha, hb;
  logic [63:0]  prod;
  logic [127:0] part;
  logic [127:0] rnd;

  always_comb begin
    ha   = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
    hb   = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];
    prod = {32'd0, ha} * {32'd0, hb};
    case (cnt_q[1:0])
      2'd0:    part = {64'd0, prod};
      2'd3:    part = {prod, 64'd0};
      default: part = {32'd0, prod, 32'd0};
    endcase
    rnd = acc_q + (128'd1 << 47);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ua_q  <= mag(a_i);
      ub_q  <= mag(b_i);
      neg_q <= a_i[63] ^ b_i[63];
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q == 3'd4) begin
        res_q <= from_mag(neg_q, (|rnd[127:112]) ? '1 : rnd[111:48], WORD_WIDTH);
      end else begin
        acc_q <= acc_q + part;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### src/bse_div.sv
// ----------------------------------------------------------------------------
// Battery SOC EKF step: gain divider
// Restoring Q15.48 division, two quotient bits a cycle, truncated and saturated.
// ----------------------------------------------------------------------------
module bse_div import bse_pkg::*; #(
  parameter int unsigned WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] n_i,
  input  logic signed [63:0] d_i,
  output logic               done_o,
  output logic signed [63:0] res_o
);

  localparam int unsigned DVD_W = 112;
  localparam int unsigned STEPS = DVD_W / 2;
  localparam int unsigned CNT_W = $clog2(STEPS + 1);

  logic              busy_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DVD_W-1:0]  dvd_q;
  logic [63:0]       rem_q, ud_q, quo_q;
  logic              ovf_q, neg_q, zero_q;
  logic              done_q;
  logic signed [63:0] res_q;

  logic [64:0] s1, s2;

  function automatic logic [64:0] dstep(logic [63:0] rem, logic b, logic [63:0] ud);
    logic [64:0] t;
    t = {rem, b};
    if (t >= {1'b0, ud}) return {1'b1, 64'(t - {1'b0, ud})};
    return {1'b0, t[63:0]};
  endfunction

  always_comb begin
    s1 = dstep(rem_q, dvd_q[DVD_W-1], ud_q);
    s2 = dstep(s1[63:0], dvd_q[DVD_W-2], ud_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CNT_W'(STEPS)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= {mag(n_i), 48'd0};
      ud_q   <= mag(d_i);
      rem_q  <= '0;
      quo_q  <= '0;
      ovf_q  <= 1'b0;
      neg_q  <= n_i[63] ^ d_i[63];
      zero_q <= (d_i == '0);
    end else if (busy_q) begin
      if (cnt_q == CNT_W'(STEPS)) begin
        res_q <= zero_q ? '0 : from_mag(neg_q, ovf_q ? '1 : quo_q, WORD_WIDTH);
      end else begin
        dvd_q <= {dvd_q[DVD_W-3:0], 2'b00};
        rem_q <= s2[63:0];
        quo_q <= {quo_q[61:0], s1[64], s2[64]};
        ovf_q <= ovf_q | (|quo_q[63:62]);
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### src/bse_ctrl.sv
// ----------------------------------------------------------------------------
// Battery SOC EKF step: sequencer
// Steps the micro-program and hands work to the multiplier and divider.
// ----------------------------------------------------------------------------
module bse_ctrl import bse_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_accept_i,
  input  op_e   op_i,
  input  logic  unit_done_i,
  input  logic  out_free_i,
  output ctrl_t ctrl_o
);

  state_e          state_q, state_d;
  logic [PC_W-1:0] pc_q, pc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    pc_d             = pc_q;
    ctrl_o           = '0;
    ctrl_o.pc        = pc_q;
    ctrl_o.busy      = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_accept_i) begin
          pc_d    = '0;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        case (op_i)
          OP_MUL: begin
            ctrl_o.mul_start = 1'b1;
            state_d          = ST_WAIT;
          end
          OP_DIV: begin
            ctrl_o.div_start = 1'b1;
            state_d          = ST_WAIT;
          end
          OP_END: begin
            if (out_free_i) begin
              ctrl_o.out_load = 1'b1;
              state_d         = ST_IDLE;
            end
          end
          default: begin
            ctrl_o.wr_en = 1'b1;
            pc_d         = pc_q + PC_W'(1);
          end
        endcase
      end
      ST_WAIT: begin
        if (unit_done_i) begin
          ctrl_o.wr_en = 1'b1;
          pc_d         = pc_q + PC_W'(1);
          state_d      = ST_ISSUE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### src/battery_soc_ekf_step.sv
// ----------------------------------------------------------------------------
// Battery SOC EKF step: top level
// One extended Kalman filter step on a first-order RC cell model per sample.
// ----------------------------------------------------------------------------
// Usage:
// Each input request carries a terminal voltage and a cell current in Q15.48
// and yields exactly one result request with the clamped state of charge and
// the polarization voltage. Both channels use valid and stall; a request moves
// when valid is high and stall is low.
// From acceptance to a valid result an item makes 28 passes through the
// shared multiplier, two gain divisions, its adds and subtracts and one
// load of the output register. A new item is accepted only once the block
// is done with the previous one; in_stall_o is high while the block works.
// A finished result sits in an output register, so a new item is accepted
// while the receiver stalls; that item holds at its end until the output
// register is free.
// Configuration writes use cfg_valid_i, cfg_index_i and cfg_data_i and are
// always ready; the user must make them while the block is idle; not enforced.
// Reset clears the configuration and out_valid_o, sets the charge state to
// 0.9, polarization voltage to zero, covariance to its starting diagonal.
// ----------------------------------------------------------------------------
module battery_soc_ekf_step import bse_pkg::*; #(
  parameter int unsigned WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [63:0] terminal_voltage_i,
  input  logic signed [63:0] cell_current_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [48:0]        charge_estimate_o,
  output logic signed [63:0] polarization_estimate_o
);

  logic [48:0]        decay_q;
  logic signed [63:0] pgain_q, cgain_q, ohmic_q;
  logic [62:0]        pnoise_q, mnoise_q;

  logic signed [63:0] pol_q, chg_q, p0_q, p1_q, p2_q, p3_q;
  logic signed [63:0] v_q, cur_q, x1_q, x2_q, pol_t_q, chg_t_q;
  logic signed [63:0] pp0_q, pp1_q, pp2_q, pp3_q, c_q, g0_q, g1_q, s_q;
  logic signed [63:0] k0_q, k1_q, res_q, h_q;

  logic               out_valid_q;
  logic [48:0]        out_chg_q;
  logic signed [63:0] out_pol_q;

  ctrl_t              ctrl;
  uop_t               uop;
  logic               in_accept;
  logic               mul_done, div_done;
  logic signed [63:0] mul_res, div_res;
  logic signed [63:0] opa, opb, wb_val;
  logic signed [63:0] a_cl, q_cl, r_cl;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = ctrl.busy;
  assign in_accept   = in_valid_i & ~ctrl.busy;
  assign uop         = prog(ctrl.pc);

  assign a_cl = sat_w({16'd0, decay_q}, WORD_WIDTH);
  assign q_cl = sat_w({2'd0, pnoise_q}, WORD_WIDTH);
  assign r_cl = sat_w({2'd0, mnoise_q}, WORD_WIDTH);

  function automatic logic signed [63:0] pick(reg_e sel);
    case (sel)
      R_A:     return a_cl;
      R_PG:    return pgain_q;
      R_CG:    return cgain_q;
      R_R0:    return ohmic_q;
      R_Q:     return q_cl;
      R_R:     return r_cl;
      R_V:     return v_q;
      R_CUR:   return cur_q;
      R_POLQ:  return pol_q;
      R_CHGQ:  return chg_q;
      R_P0:    return p0_q;
      R_P1:    return p1_q;
      R_P2:    return p2_q;
      R_P3:    return p3_q;
      R_X1:    return x1_q;
      R_X2:    return x2_q;
      R_POL:   return pol_t_q;
      R_CHG:   return chg_t_q;
      R_PP0:   return pp0_q;
      R_PP1:   return pp1_q;
      R_PP2:   return pp2_q;
      R_PP3:   return pp3_q;
      R_C:     return c_q;
      R_G0:    return g0_q;
      R_G1:    return g1_q;
      R_S:     return s_q;
      R_K0:    return k0_q;
      R_K1:    return k1_q;
      R_RES:   return res_q;
      R_H:     return h_q;
      R_D0:    return DOCV_C0;
      R_D1:    return DOCV_C1;
      R_D2:    return DOCV_C2;
      R_D3:    return DOCV_C3;
      R_D4:    return DOCV_C4;
      R_O0:    return OCV_C0;
      R_O1:    return OCV_C1;
      R_O2:    return OCV_C2;
      R_O3:    return OCV_C3;
      R_O4:    return OCV_C4;
      R_O5:    return OCV_C5;
      default: return '0;
    endcase
  endfunction

  always_comb begin
    opa = pick(uop.src_a);
    opb = pick(uop.src_b);
    case (uop.op)
      OP_ADD:   wb_val = sat_w(65'(opa) + 65'(opb), WORD_WIDTH);
      OP_SUB:   wb_val = sat_w(65'(opa) - 65'(opb), WORD_WIDTH);
      OP_ADDCL: wb_val = clamp01(sat_w(65'(opa) + 65'(opb), WORD_WIDTH));
      OP_MUL:   wb_val = mul_res;
      OP_DIV:   wb_val = div_res;
      default:  wb_val = '0;
    endcase
  end

  bse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .op_i        (uop.op),
    .unit_done_i (mul_done | div_done),
    .out_free_i  (~out_valid_q | ~out_stall_i),
    .ctrl_o      (ctrl)
  );

  bse_mul #(.WORD_WIDTH(WORD_WIDTH)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl.mul_start),
    .a_i     (opa),
    .b_i     (opb),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  bse_div #(.WORD_WIDTH(WORD_WIDTH)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl.div_start),
    .n_i     (opa),
    .d_i     (opb),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q  <= '0;
      pgain_q  <= '0;
      cgain_q  <= '0;
      ohmic_q  <= '0;
      pnoise_q <= '0;
      mnoise_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DECAY:  decay_q  <= cfg_data_i[48:0];
        CFG_PGAIN:  pgain_q  <= cfg_data_i;
        CFG_CGAIN:  cgain_q  <= cfg_data_i;
        CFG_OHMIC:  ohmic_q  <= cfg_data_i;
        CFG_PNOISE: pnoise_q <= cfg_data_i[62:0];
        CFG_MNOISE: mnoise_q <= cfg_data_i[62:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pol_q <= '0;
      chg_q <= CHG_RESET;
      p0_q  <= COV0_RESET;
      p1_q  <= '0;
      p2_q  <= '0;
      p3_q  <= COV3_RESET;
    end else if (ctrl.wr_en) begin
      case (uop.dst)
        R_POLQ:  pol_q <= wb_val;
        R_CHGQ:  chg_q <= wb_val;
        R_P0:    p0_q  <= wb_val;
        R_P1:    p1_q  <= wb_val;
        R_P2:    p2_q  <= wb_val;
        R_P3:    p3_q  <= wb_val;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      v_q   <= sat_w({terminal_voltage_i[63], terminal_voltage_i}, WORD_WIDTH);
      cur_q <= sat_w({cell_current_i[63], cell_current_i}, WORD_WIDTH);
    end
    if (ctrl.wr_en) begin
      case (uop.dst)
        R_X1:    x1_q    <= wb_val;
        R_X2:    x2_q    <= wb_val;
        R_POL:   pol_t_q <= wb_val;
        R_CHG:   chg_t_q <= wb_val;
        R_PP0:   pp0_q   <= wb_val;
        R_PP1:   pp1_q   <= wb_val;
        R_PP2:   pp2_q   <= wb_val;
        R_PP3:   pp3_q   <= wb_val;
        R_C:     c_q     <= wb_val;
        R_G0:    g0_q    <= wb_val;
        R_G1:    g1_q    <= wb_val;
        R_S:     s_q     <= wb_val;
        R_K0:    k0_q    <= wb_val;
        R_K1:    k1_q    <= wb_val;
        R_RES:   res_q   <= wb_val;
        R_H:     h_q     <= wb_val;
        default: ;
      endcase
    end
    if (ctrl.out_load) begin
      out_chg_q <= chg_q[48:0];
      out_pol_q <= pol_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign charge_estimate_o       = out_chg_q;
  assign polarization_estimate_o = out_pol_q;

endmodule

### src/bse_checker.sv
// ----------------------------------------------------------------------------
// Battery SOC EKF step: port checker
// Watches the top level ports and reports violations of expected behavior.
// ----------------------------------------------------------------------------
module bse_checker import bse_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [48:0]        charge_estimate_o,
  input logic signed [63:0] polarization_estimate_o
);

  // The block stalls its input after it takes a sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block accepted a second request right after the first");

  // A new result cannot appear right after a sample is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result appeared one cycle after acceptance");

  // While valid, the charge estimate is within zero to one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> charge_estimate_o <= 49'(ONE_Q))
    else $error("charge estimate above one");

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(charge_estimate_o)
      && $stable(polarization_estimate_o))
    else $error("stalled result changed");

endmodule

bind battery_soc_ekf_step bse_checker u_bse_checker (.*);
